FILE: rtl/core/best_fit_allocator_with_coalescing_core_defines.svh
// assertion macros for the allocator core checker
`ifndef BEST_FIT_ALLOCATOR_WITH_COALESCING_CORE_DEFINES_SVH
`define BEST_FIT_ALLOCATOR_WITH_COALESCING_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BFAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BFAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bfac_pkg.sv
// shared types, constants and codes of the allocator core
`timescale 1ns / 1ps
package bfac_pkg;

    localparam int FREE_SLOTS_DEF = 64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_POOL = 2'd1;
    localparam logic [1:0] CFG_COPY = 2'd2;

    localparam logic [31:0] POOL_RESET = 32'd67108864;
    localparam logic [12:0] COPY_RESET = 13'd1;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_SCAN_A   = 5'd2;
    localparam logic [4:0] OP_SCAN_F   = 5'd3;
    localparam logic [4:0] OP_SPLIT    = 5'd4;
    localparam logic [4:0] OP_RMV_INIT = 5'd5;
    localparam logic [4:0] OP_SHDN     = 5'd6;
    localparam logic [4:0] OP_RMV_END  = 5'd7;
    localparam logic [4:0] OP_BUMP     = 5'd8;
    localparam logic [4:0] OP_WR_PREV  = 5'd9;
    localparam logic [4:0] OP_WR_NEXT  = 5'd10;
    localparam logic [4:0] OP_INS_INIT = 5'd11;
    localparam logic [4:0] OP_SHUP     = 5'd12;
    localparam logic [4:0] OP_INS_WR   = 5'd13;
    localparam logic [4:0] OP_LAST_RD  = 5'd14;
    localparam logic [4:0] OP_RETRACT  = 5'd15;
    localparam logic [4:0] OP_MUL      = 5'd16;
    localparam logic [4:0] OP_USED     = 5'd17;
    localparam logic [4:0] OP_RESULT   = 5'd18;

    typedef struct packed {
        logic        cmd;
        logic [31:0] block_bytes;
        logic [31:0] block_address;
    } bfac_req_t;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [1:0]  status;
        logic [47:0] bytes_in_use;
        logic [31:0] top_offset;
    } bfac_rsp_t;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] res_status;
    } bfac_ctl_t;

    typedef struct packed {
        logic is_free;
        logic step_done;
        logic found;
        logic split;
        logic oom;
        logic mp;
        logic mn;
        logic full;
        logic out_free;
    } bfac_sts_t;

endpackage

FILE: rtl/core/best_fit_allocator_with_coalescing_core.sv
// top level of the best-fit allocator core with coalescing free table
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  bfac_req_t  (cmd, block_bytes, block_address)
//  m_        out        m_valid / m_ready  bfac_rsp_t  (granted_address, status, ...)
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// one request at a time; the free table is a single-port-read memory walked one
// entry per cycle by a scan plus an optional shift pass, so the time a request
// takes grows with the number of table entries (up to FREE_SLOTS, 64 by default).
// reset is synchronous active low and clears counters, no memory clearing pass.
// a finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result is ready and m_ready is low.
`timescale 1ns / 1ps
module best_fit_allocator_with_coalescing_core
    import bfac_pkg::*;
#(
    parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bfac_req_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bfac_rsp_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);
    bfac_ctl_t ctl;
    bfac_sts_t sts;

    bfac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    bfac_datapath #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: rtl/core/bfac_datapath.sv
// free table memory, counters, pool registers and result register
`timescale 1ns / 1ps
module bfac_datapath
    import bfac_pkg::*;
#(
    parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  bfac_req_t   s_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  bfac_ctl_t   ctl,
    output bfac_sts_t   sts,
    output logic        m_valid,
    input  logic        m_ready,
    output bfac_rsp_t   m_data
);
    localparam int IW = $clog2(FREE_SLOTS);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);

    logic [31:0] mem_start [FREE_SLOTS];
    logic [31:0] mem_len   [FREE_SLOTS];

    logic [31:0] base_reg, pool_reg;
    logic [12:0] copy_reg;
    bfac_req_t   req_reg;
    logic [CW-1:0] idx_reg, idx_next, cnt_reg, cnt_next, pos_reg, pos_next;
    logic [CW-1:0] rd_idx_reg;
    logic        rd_vld_reg;
    logic [31:0] rd_start_reg, rd_len_reg;
    logic [31:0] bump_reg, bump_next;
    logic [47:0] used_reg, used_next;
    logic [44:0] prod_reg;
    logic        found_reg, found_next, stop_reg, stop_next;
    logic        prev_ok_reg, prev_ok_next, nxt_ok_reg, nxt_ok_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_start_reg, best_start_next, best_len_reg, best_len_next;
    logic [31:0] prev_start_reg, prev_start_next, prev_len_reg, prev_len_next;
    logic [31:0] nxt_start_reg, nxt_start_next, nxt_len_reg, nxt_len_next;
    logic [31:0] grant_reg, grant_next;
    logic        lr_ok_reg;
    logic        out_vld_reg;
    bfac_rsp_t   out_reg;

    logic          rd_en, wr_en;
    logic [CW-1:0] rd_addr_w;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_start, wr_len;
    logic [33:0]   merge_sum;
    logic [31:0]   merge_len, next_len;
    logic [32:0]   nxt_sum;
    logic [32:0]   ret_end, top_abs;
    logic [CW-1:0] rmv_base;

    // merge lengths saturate at 32 bits
    assign merge_sum = {2'b0, prev_len_reg} + {2'b0, req_reg.block_bytes}
                     + (sts.mn ? {2'b0, nxt_len_reg} : 34'd0);
    assign merge_len = (merge_sum[33:32] != 2'b0) ? 32'hFFFF_FFFF : merge_sum[31:0];
    assign nxt_sum   = {1'b0, req_reg.block_bytes} + {1'b0, nxt_len_reg};
    assign next_len  = nxt_sum[32] ? 32'hFFFF_FFFF : nxt_sum[31:0];
    assign ret_end   = {1'b0, rd_start_reg} + {1'b0, rd_len_reg};
    assign top_abs   = {1'b0, base_reg} + {1'b0, bump_reg};
    assign rmv_base  = req_reg.cmd ? pos_reg : best_idx_reg;

    always_comb begin
        sts.is_free  = req_reg.cmd;
        sts.found    = found_reg;
        sts.split    = best_len_reg > req_reg.block_bytes;
        sts.oom      = ({1'b0, bump_reg} + {1'b0, req_reg.block_bytes}) > {1'b0, pool_reg};
        sts.mp       = prev_ok_reg && (({1'b0, prev_start_reg} + {1'b0, prev_len_reg})
                       == {1'b0, req_reg.block_address});
        sts.mn       = nxt_ok_reg && (({1'b0, req_reg.block_address}
                       + {1'b0, req_reg.block_bytes}) == {1'b0, nxt_start_reg});
        sts.full     = cnt_reg == SLOTS_C;
        sts.out_free = !out_vld_reg || m_ready;
        unique case (ctl.op)
            OP_SCAN_A, OP_SHDN: sts.step_done = (idx_reg >= cnt_reg) && !rd_vld_reg;
            OP_SCAN_F: sts.step_done = stop_reg || ((idx_reg >= cnt_reg) && !rd_vld_reg);
            OP_SHUP:   sts.step_done = (idx_reg <= pos_reg) && !rd_vld_reg;
            default:   sts.step_done = 1'b0;
        endcase
    end

    always_comb begin
        rd_en     = 1'b0;
        rd_addr_w = idx_reg;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_start  = rd_start_reg;
        wr_len    = rd_len_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        bump_next = bump_reg;
        used_next = used_reg;
        found_next = found_reg;
        stop_next  = stop_reg;
        prev_ok_next = prev_ok_reg;
        nxt_ok_next  = nxt_ok_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        nxt_start_next  = nxt_start_reg;
        nxt_len_next    = nxt_len_reg;
        grant_next      = grant_reg;
        unique case (ctl.op)
            OP_LOAD: begin
                idx_next = '0;
                pos_next = '0;
                found_next = 1'b0;
                stop_next = 1'b0;
                prev_ok_next = 1'b0;
                nxt_ok_next = 1'b0;
                grant_next = '0;
            end
            OP_SCAN_A: begin
                rd_en = idx_reg < cnt_reg;
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg && rd_len_reg >= req_reg.block_bytes
                    && (!found_reg || rd_len_reg < best_len_reg)) begin
                    found_next = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_start_next = rd_start_reg;
                    best_len_next = rd_len_reg;
                end
            end
            OP_SCAN_F: begin
                rd_en = (idx_reg < cnt_reg) && !stop_reg;
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg && !stop_reg) begin
                    if (rd_start_reg <= req_reg.block_address) begin
                        prev_ok_next = 1'b1;
                        prev_start_next = rd_start_reg;
                        prev_len_next = rd_len_reg;
                        pos_next = rd_idx_reg + 1'b1;
                    end else begin
                        nxt_ok_next = 1'b1;
                        nxt_start_next = rd_start_reg;
                        nxt_len_next = rd_len_reg;
                        stop_next = 1'b1;
                    end
                end
            end
            OP_SPLIT: begin
                wr_en = 1'b1;
                wr_addr = best_idx_reg[IW-1:0];
                wr_start = best_start_reg + req_reg.block_bytes;
                wr_len = best_len_reg - req_reg.block_bytes;
                grant_next = best_start_reg;
            end
            OP_RMV_INIT: begin
                idx_next = rmv_base + 1'b1;
                if (!req_reg.cmd) begin
                    grant_next = best_start_reg;
                end
            end
            OP_SHDN: begin
                rd_en = idx_reg < cnt_reg;
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    wr_en = 1'b1;
                    wr_addr = IW'(rd_idx_reg - 1'b1);
                end
            end
            OP_RMV_END: cnt_next = cnt_reg - 1'b1;
            OP_BUMP: begin
                grant_next = base_reg + bump_reg;
                bump_next = bump_reg + req_reg.block_bytes;
            end
            OP_WR_PREV: begin
                wr_en = 1'b1;
                wr_addr = IW'(pos_reg - 1'b1);
                wr_start = prev_start_reg;
                wr_len = merge_len;
            end
            OP_WR_NEXT: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[IW-1:0];
                wr_start = req_reg.block_address;
                wr_len = next_len;
            end
            OP_INS_INIT: idx_next = cnt_reg;
            OP_SHUP: begin
                rd_en = idx_reg > pos_reg;
                rd_addr_w = idx_reg - 1'b1;
                if (rd_en) begin
                    idx_next = idx_reg - 1'b1;
                end
                if (rd_vld_reg) begin
                    wr_en = 1'b1;
                    wr_addr = IW'(rd_idx_reg + 1'b1);
                end
            end
            OP_INS_WR: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[IW-1:0];
                wr_start = req_reg.block_address;
                wr_len = req_reg.block_bytes;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_LAST_RD: begin
                rd_en = cnt_reg != '0;
                rd_addr_w = cnt_reg - 1'b1;
            end
            OP_RETRACT: begin
                if (lr_ok_reg && ret_end == top_abs) begin
                    bump_next = (rd_len_reg > bump_reg) ? 32'd0 : bump_reg - rd_len_reg;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_USED: begin
                used_next = req_reg.cmd ? used_reg - {3'b0, prod_reg}
                                        : used_reg + {3'b0, prod_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_start_reg <= mem_start[rd_addr_w[IW-1:0]];
            rd_len_reg   <= mem_len[rd_addr_w[IW-1:0]];
        end
        if (wr_en) begin
            mem_start[wr_addr] <= wr_start;
            mem_len[wr_addr]   <= wr_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            pool_reg <= POOL_RESET;
            copy_reg <= COPY_RESET;
            cnt_reg <= '0;
            bump_reg <= '0;
            used_reg <= '0;
            rd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BASE: base_reg <= cfg_wr_data;
                    CFG_POOL: pool_reg <= cfg_wr_data;
                    CFG_COPY: copy_reg <= cfg_wr_data[12:0];
                    default: ;
                endcase
            end
            cnt_reg <= cnt_next;
            bump_reg <= bump_next;
            used_reg <= used_next;
            rd_vld_reg <= rd_en;
            if (ctl.op == OP_RESULT) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == OP_LOAD) begin
            req_reg <= s_data;
        end
        if (ctl.op == OP_MUL) begin
            prod_reg <= req_reg.block_bytes * copy_reg;
        end
        if (ctl.op == OP_RESULT) begin
            out_reg.granted_address <= (ctl.res_status == ST_OK) ? grant_reg : 32'd0;
            out_reg.status <= ctl.res_status;
            out_reg.bytes_in_use <= used_reg;
            out_reg.top_offset <= bump_reg;
        end
        rd_idx_reg <= rd_addr_w;
        lr_ok_reg <= cnt_reg != '0;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        found_reg <= found_next;
        stop_reg <= stop_next;
        prev_ok_reg <= prev_ok_next;
        nxt_ok_reg <= nxt_ok_next;
        best_idx_reg <= best_idx_next;
        best_start_reg <= best_start_next;
        best_len_reg <= best_len_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg <= prev_len_next;
        nxt_start_reg <= nxt_start_next;
        nxt_len_reg <= nxt_len_next;
        grant_reg <= grant_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/core/bfac_ctrl.sv
// request sequencer for the allocator core
`timescale 1ns / 1ps
module bfac_ctrl
    import bfac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bfac_sts_t sts,
    output bfac_ctl_t ctl
);
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_A_SCAN   = 5'd1;
    localparam logic [4:0] S_A_SPLIT  = 5'd2;
    localparam logic [4:0] S_RMV_INIT = 5'd3;
    localparam logic [4:0] S_SHDN     = 5'd4;
    localparam logic [4:0] S_RMV_END  = 5'd5;
    localparam logic [4:0] S_A_BUMP   = 5'd6;
    localparam logic [4:0] S_F_SCAN   = 5'd7;
    localparam logic [4:0] S_WR_PREV  = 5'd8;
    localparam logic [4:0] S_WR_NEXT  = 5'd9;
    localparam logic [4:0] S_INS_INIT = 5'd10;
    localparam logic [4:0] S_SHUP     = 5'd11;
    localparam logic [4:0] S_INS_WR   = 5'd12;
    localparam logic [4:0] S_LAST_RD  = 5'd13;
    localparam logic [4:0] S_RETRACT  = 5'd14;
    localparam logic [4:0] S_MUL      = 5'd15;
    localparam logic [4:0] S_USED     = 5'd16;
    localparam logic [4:0] S_RESULT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [1:0] res_reg, res_next;

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        res_next = res_reg;
        ctl.op = OP_NONE;
        ctl.res_status = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.op = OP_LOAD;
                    res_next = ST_OK;
                    state_next = S_F_SCAN;
                    // command bit is only visible in the cycle after the load, so peek by scan type
                end
            end
            S_F_SCAN: begin
                // first cycle after load decides which scan to run
                ctl.op = sts.is_free ? OP_SCAN_F : OP_SCAN_A;
                if (!sts.is_free) begin
                    state_next = S_A_SCAN;
                end else if (sts.step_done) begin
                    if (sts.mp) begin
                        state_next = S_WR_PREV;
                    end else if (sts.mn) begin
                        state_next = S_WR_NEXT;
                    end else if (sts.full) begin
                        res_next = ST_FULL;
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_INS_INIT;
                    end
                end
            end
            S_A_SCAN: begin
                ctl.op = OP_SCAN_A;
                if (sts.step_done) begin
                    if (!sts.found) begin
                        state_next = S_A_BUMP;
                    end else if (sts.split) begin
                        state_next = S_A_SPLIT;
                    end else begin
                        state_next = S_RMV_INIT;
                    end
                end
            end
            S_A_SPLIT: begin
                ctl.op = OP_SPLIT;
                state_next = S_MUL;
            end
            S_RMV_INIT: begin
                ctl.op = OP_RMV_INIT;
                state_next = S_SHDN;
            end
            S_SHDN: begin
                ctl.op = OP_SHDN;
                if (sts.step_done) begin
                    state_next = S_RMV_END;
                end
            end
            S_RMV_END: begin
                ctl.op = OP_RMV_END;
                state_next = sts.is_free ? S_LAST_RD : S_MUL;
            end
            S_A_BUMP: begin
                if (sts.oom) begin
                    res_next = ST_OOM;
                    state_next = S_RESULT;
                end else begin
                    ctl.op = OP_BUMP;
                    state_next = S_MUL;
                end
            end
            S_WR_PREV: begin
                ctl.op = OP_WR_PREV;
                state_next = sts.mn ? S_RMV_INIT : S_LAST_RD;
            end
            S_WR_NEXT: begin
                ctl.op = OP_WR_NEXT;
                state_next = S_LAST_RD;
            end
            S_INS_INIT: begin
                ctl.op = OP_INS_INIT;
                state_next = S_SHUP;
            end
            S_SHUP: begin
                ctl.op = OP_SHUP;
                if (sts.step_done) begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                ctl.op = OP_INS_WR;
                state_next = S_LAST_RD;
            end
            S_LAST_RD: begin
                ctl.op = OP_LAST_RD;
                state_next = S_RETRACT;
            end
            S_RETRACT: begin
                ctl.op = OP_RETRACT;
                state_next = S_MUL;
            end
            S_MUL: begin
                ctl.op = OP_MUL;
                state_next = S_USED;
            end
            S_USED: begin
                ctl.op = OP_USED;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    ctl.op = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg <= ST_OK;
        end else begin
            state_reg <= state_next;
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/core/bfac_checker.sv
// port-level checker for the allocator core, bound to the top level
`timescale 1ns / 1ps
`include "best_fit_allocator_with_coalescing_core_defines.svh"
module bfac_checker
    import bfac_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input bfac_rsp_t m_data
);
    `BFAC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `BFAC_ASSERT_NOW(a_fail_no_grant, aclk, aresetn, m_valid && m_data.status != ST_OK, m_data.granted_address == 32'd0, "failed request carries an address")
    `BFAC_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_data.status == ST_OK || m_data.status == ST_OOM || m_data.status == ST_FULL, "unknown status code")
    `BFAC_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "second request taken while busy")

endmodule

bind best_fit_allocator_with_coalescing_core bfac_checker u_bfac_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/best_fit_allocator_with_coalescing_core_tb.sv
// self-checking testbench for the best-fit allocator core with coalescing free table
`timescale 1ns / 1ps
module best_fit_allocator_with_coalescing_core_tb;
    import bfac_pkg::*;

    localparam int SLOTS = FREE_SLOTS_DEF;
    localparam int DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 4000000;
    // register index beyond the list, must be ignored
    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;

    // software copy of the allocator: config, free table, counters
    class alloc_scoreboard;
        logic [31:0] base_addr;
        logic [31:0] pool_size;
        logic [12:0] copies;
        logic [31:0] fstart[SLOTS + 1];
        logic [31:0] flen[SLOTS + 1];
        int          nfree;
        logic [31:0] bump;
        logic [47:0] used;
        bfac_rsp_t   pending[$];
        int          errors;
        int          checked;

        function new();
            base_addr = 32'd0;
            pool_size = POOL_RESET;
            copies = COPY_RESET;
            nfree = 0;
            bump = 32'd0;
            used = 48'd0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_BASE) base_addr = val;
            else if (idx == CFG_POOL) pool_size = val;
            else if (idx == CFG_COPY) copies = val[12:0];
        endfunction

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < nfree; i++) begin
                fstart[i] = fstart[i + 1];
                flen[i] = flen[i + 1];
            end
            nfree--;
        endfunction

        function logic [31:0] sat(logic [33:0] v);
            return (v > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function logic [1:0] allocate(logic [31:0] n, output logic [31:0] grant);
            int best;
            bit found;
            logic [31:0] blen;
            best = 0;
            found = 0;
            blen = 0;
            grant = 0;
            for (int i = 0; i < nfree; i++) begin
                if (flen[i] >= n && (!found || flen[i] < blen)) begin
                    found = 1;
                    best = i;
                    blen = flen[i];
                end
            end
            if (found) begin
                grant = fstart[best];
                if (blen > n) begin
                    fstart[best] = fstart[best] + n;
                    flen[best] = blen - n;
                end else begin
                    drop_entry(best);
                end
            end else begin
                if ({1'b0, bump} + {1'b0, n} > {1'b0, pool_size}) return ST_OOM;
                grant = base_addr + bump;
                bump = bump + n;
            end
            used = used + 48'(n) * 48'(copies);
            return ST_OK;
        endfunction

        function logic [1:0] release_block(logic [31:0] addr, logic [31:0] size);
            int pos;
            bit mp, mn;
            logic [32:0] tail;
            pos = 0;
            while (pos < nfree && fstart[pos] <= addr) pos++;
            mp = pos > 0 && ({1'b0, fstart[pos - 1]} + flen[pos - 1]) == {1'b0, addr};
            mn = pos < nfree && ({1'b0, addr} + size) == {1'b0, fstart[pos]};
            if (!mp && !mn && nfree >= SLOTS) return ST_FULL;
            if (mp && mn) begin
                flen[pos - 1] = sat(34'(flen[pos - 1]) + size + flen[pos]);
                drop_entry(pos);
            end else if (mp) begin
                flen[pos - 1] = sat(34'(flen[pos - 1]) + size);
            end else if (mn) begin
                fstart[pos] = addr;
                flen[pos] = sat(34'(size) + flen[pos]);
            end else begin
                for (int i = nfree; i > pos; i--) begin
                    fstart[i] = fstart[i - 1];
                    flen[i] = flen[i - 1];
                end
                fstart[pos] = addr;
                flen[pos] = size;
                nfree++;
            end
            if (nfree > 0) begin
                tail = {1'b0, fstart[nfree - 1]} + flen[nfree - 1];
                if (tail == {1'b0, base_addr} + bump) begin
                    bump = (flen[nfree - 1] > bump) ? 32'd0 : bump - flen[nfree - 1];
                    nfree--;
                end
            end
            used = used - 48'(size) * 48'(copies);
            return ST_OK;
        endfunction

        function void note_request(bfac_req_t r);
            bfac_rsp_t e;
            logic [31:0] g;
            g = 0;
            if (r.cmd == CMD_ALLOC) e.status = allocate(r.block_bytes, g);
            else e.status = release_block(r.block_address, r.block_bytes);
            e.granted_address = (e.status == ST_OK) ? g : 32'd0;
            e.bytes_in_use = used;
            e.top_offset = bump;
            pending = {pending, e};
        endfunction

        task report(string what, logic [47:0] got, logic [47:0] want);
            errors++;
            if (errors <= 30)
                $display("mismatch %s: got %0h expected %0h (result %0d)",
                         what, got, want, checked);
        endtask

        task check_result(bfac_rsp_t r);
            bfac_rsp_t e;
            if (pending.size() == 0) begin
                report("unexpected result", 48'(r.status), 48'd0);
                return;
            end
            e = pending.pop_front();
            if (r.granted_address !== e.granted_address)
                report("granted_address", 48'(r.granted_address), 48'(e.granted_address));
            if (r.status !== e.status) report("status", 48'(r.status), 48'(e.status));
            if (r.bytes_in_use !== e.bytes_in_use)
                report("bytes_in_use", r.bytes_in_use, e.bytes_in_use);
            if (r.top_offset !== e.top_offset)
                report("top_offset", 48'(r.top_offset), 48'(e.top_offset));
            checked++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bfac_req_t   s_data;
    logic        m_valid;
    logic        m_ready;
    bfac_rsp_t   m_data;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wr_data;

    alloc_scoreboard sb;
    longint cycles;
    int     n_alloc, n_free, n_oom, n_full;
    logic [31:0] live_addr[$];
    logic [31:0] live_size[$];

    best_fit_allocator_with_coalescing_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("best_fit_allocator_with_coalescing_core test failed");
                $finish;
            end
        end
    end

    // result side: random stalls, checked at the accepting edge
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
            if (m_data.status == ST_OOM) n_oom++;
            if (m_data.status == ST_FULL) n_full++;
        end
    end

    bit burst;

    task automatic send(logic cmd, logic [31:0] bytes, logic [31:0] addr);
        bfac_req_t r;
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        r.cmd = cmd;
        r.block_bytes = bytes;
        r.block_address = addr;
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        if (cmd == CMD_ALLOC) n_alloc++;
        else n_free++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // allocate and remember the grant for a later free
    task automatic alloc_track(logic [31:0] bytes);
        logic [31:0] exp_addr;
        send(CMD_ALLOC, bytes, $urandom());
        if (sb.pending[$].status == ST_OK) begin
            exp_addr = sb.pending[$].granted_address;
            live_addr = {live_addr, exp_addr};
            live_size = {live_size, bytes};
        end
    endtask

    task automatic free_random_live();
        int k;
        k = $urandom_range(0, live_addr.size() - 1);
        send(CMD_FREE, live_size[k], live_addr[k]);
        live_addr.delete(k);
        live_size.delete(k);
    endtask

    task automatic random_phase(int count, int max_size);
        int kind;
        for (int i = 0; i < count; i++) begin
            burst = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 50 || live_addr.size() == 0) begin
                alloc_track($urandom_range(0, max_size));
            end else if (kind < 90) begin
                free_random_live();
            end else if (kind < 95) begin
                send(1'($urandom_range(0, 1)), $urandom(), $urandom());
            end else begin
                alloc_track($urandom());
            end
        end
        burst = 0;
    endtask

    initial begin
        sb = new();
        n_alloc = 0; n_free = 0; n_oom = 0; n_full = 0;
        burst = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_BASE;
        cfg_wr_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero sizes, exact fit, split, coalescing, retraction, oom
        send(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send(CMD_ALLOC, 32'd100, 32'd0);
        send(CMD_ALLOC, 32'd50, 32'd0);
        send(CMD_ALLOC, 32'd100, 32'd0);
        send(CMD_ALLOC, 32'd10, 32'd0);
        send(CMD_FREE, 32'd100, 32'd0);
        send(CMD_FREE, 32'd100, 32'd150);
        send(CMD_ALLOC, 32'd100, 32'd0);
        send(CMD_ALLOC, 32'd40, 32'd0);
        send(CMD_FREE, 32'd50, 32'd100);
        send(CMD_FREE, 32'd0, 32'd20);
        send(CMD_FREE, 32'd10, 32'd250);
        send(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_FREE, 32'hFFFF_FFFF, 32'd0);
        wait_idle();

        // extremes of the registers, wrapped grant and saturation
        write_cfg(CFG_BASE, 32'hFFFF_FF00);
        write_cfg(CFG_POOL, 32'hFFFF_FFFF);
        write_cfg(CFG_COPY, 32'd4096);
        send(CMD_ALLOC, 32'h8000_0000, 32'd0);
        send(CMD_ALLOC, 32'h7FFF_FFFF, 32'd0);
        send(CMD_ALLOC, 32'd1, 32'd0);
        send(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_FREE, 32'hFFFF_FFFF, 32'h7FFF_FF00);
        send(CMD_FREE, 32'hFFFF_FFFF, 32'd0);
        wait_idle();
        write_cfg(CFG_COPY, 32'd0);
        write_cfg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
        send(CMD_ALLOC, 32'd5, 32'd0);
        wait_idle();

        // fill the free table with isolated blocks so it overflows
        write_cfg(CFG_BASE, 32'd0);
        write_cfg(CFG_POOL, 32'd1000000);
        write_cfg(CFG_COPY, 32'd3);
        live_addr.delete();
        live_size.delete();
        for (int i = 0; i < 2 * SLOTS + 4; i++) alloc_track(32'd16);
        for (int i = 0; i < SLOTS + 3; i++) send(CMD_FREE, 32'd16, 32'h0010_0000 + 64 * i);
        send(CMD_FREE, 32'd16, 32'd0);
        send(CMD_FREE, 32'd16, 32'd16);
        wait_idle();

        // random phases under several settings
        random_phase(300, 200);
        wait_idle();
        write_cfg(CFG_BASE, $urandom());
        write_cfg(CFG_COPY, 32'd1);
        write_cfg(CFG_POOL, 32'd5000);
        live_addr.delete();
        live_size.delete();
        random_phase(300, 400);
        wait_idle();
        write_cfg(CFG_COPY, 32'd4096);
        write_cfg(CFG_POOL, 32'hFFFF_FFFF);
        random_phase(300, 100000);
        wait_idle();
        write_cfg(CFG_COPY, $urandom_range(1, 4095));
        write_cfg(CFG_POOL, 32'd0);
        random_phase(250, 64);
        wait_idle();

        $display("covered %0d allocates and %0d frees under several pool settings",
                 n_alloc, n_free);
        $display("saw %0d out-of-memory and %0d table-full results, %0d checked",
                 n_oom, n_full, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("best_fit_allocator_with_coalescing_core test passed");
        end else begin
            $display("best_fit_allocator_with_coalescing_core test failed");
        end
        $finish;
    end
endmodule

FILE: best_fit_allocator_with_coalescing_core.f
+incdir+rtl/core
rtl/core/bfac_pkg.sv
rtl/core/bfac_datapath.sv
rtl/core/bfac_ctrl.sv
rtl/core/best_fit_allocator_with_coalescing_core.sv
rtl/core/bfac_checker.sv
tb/best_fit_allocator_with_coalescing_core_tb.sv
